### rtl/point_in_triangle_barycentric_unit_macros.svh
// assertion macros used by the port-level checker
`ifndef POINT_IN_TRIANGLE_BARYCENTRIC_UNIT_MACROS_SVH
`define POINT_IN_TRIANGLE_BARYCENTRIC_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define PITB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define PITB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/pitb_pkg.sv
// constants and types for the barycentric point-in-triangle unit
package pitb_pkg;

  localparam int LIMIT_WIDTH = 32;

  typedef logic [LIMIT_WIDTH-1:0] limit_t;

  localparam limit_t LIMIT_RESET = 32'd1;

  // number of register stages from query beat to result register
  localparam int NUM_STAGES = 8;

endpackage

### rtl/point_in_triangle_barycentric_unit.sv
// eight-stage pipelined barycentric point-in-triangle test with degenerate detection
// throughput: one query per cycle while result_ready does not stall the pipeline,
// set by the per-stage valid/enable chain of the pipeline
// each stage holds its beat while the next stage is full and stalled; bubbles close up
// reset (rst, synchronous, active high) empties every stage and sets degenerate_limit to 1
// the wide products are split into two partial products over two stages
module point_in_triangle_barycentric_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_wen,
  input  logic [pitb_pkg::LIMIT_WIDTH-1:0] cfg_wdata,
  // query channel
  input  logic                          query_valid,
  output logic                          query_ready,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic signed [COORD_WIDTH-1:0] corner_a_x,
  input  logic signed [COORD_WIDTH-1:0] corner_a_y,
  input  logic signed [COORD_WIDTH-1:0] corner_a_z,
  input  logic signed [COORD_WIDTH-1:0] corner_b_x,
  input  logic signed [COORD_WIDTH-1:0] corner_b_y,
  input  logic signed [COORD_WIDTH-1:0] corner_b_z,
  input  logic signed [COORD_WIDTH-1:0] corner_c_x,
  input  logic signed [COORD_WIDTH-1:0] corner_c_y,
  input  logic signed [COORD_WIDTH-1:0] corner_c_z,
  // result channel
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic                          inside_res,
  output logic                          degenerate
);

  // edge vector width, single product, dot product
  localparam int EW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * EW;
  localparam int DW  = PW + 2;
  // split of the second multiplier operand: unsigned low part, signed high part
  localparam int LW  = (DW + 1) / 2;
  localparam int HW  = DW - LW;
  localparam int LOW = DW + LW + 1;
  localparam int HIW = DW + HW;
  // full wide product and the numerator/denominator width (room for den - nv - nw)
  localparam int PRW = 2 * DW;
  localparam int NW  = PRW + 3;
  localparam int NS  = pitb_pkg::NUM_STAGES;
  localparam int LMW = pitb_pkg::LIMIT_WIDTH;

  // configuration register
  pitb_pkg::limit_t degenerate_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      degenerate_limit <= pitb_pkg::LIMIT_RESET;
    end else if (cfg_wen) begin
      degenerate_limit <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control: stage k loads when it is empty or its beat moves on
  // ---------------------------------------------------------------------------
  logic [NS-1:0] stage_valid;
  logic [NS-1:0] stage_en;

  always_comb begin
    stage_en[NS-1] = !stage_valid[NS-1] || result_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      stage_en[i] = !stage_valid[i] || stage_en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_en[0]) begin
        stage_valid[0] <= query_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (stage_en[i]) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
    end
  end

  assign query_ready  = stage_en[0];
  assign result_valid = stage_valid[NS-1];

  // ---------------------------------------------------------------------------
  // stage 1: edge vectors e0 = b - a, e1 = c - a, e2 = p - a
  // ---------------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] pt [3];
  logic signed [COORD_WIDTH-1:0] ca [3];
  logic signed [COORD_WIDTH-1:0] cb [3];
  logic signed [COORD_WIDTH-1:0] cc [3];

  assign pt = '{point_x, point_y, point_z};
  assign ca = '{corner_a_x, corner_a_y, corner_a_z};
  assign cb = '{corner_b_x, corner_b_y, corner_b_z};
  assign cc = '{corner_c_x, corner_c_y, corner_c_z};

  logic signed [EW-1:0] e0 [3];
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      for (int i = 0; i < 3; i++) begin
        e0[i] <= EW'(cb[i]) - EW'(ca[i]);
        e1[i] <= EW'(cc[i]) - EW'(ca[i]);
        e2[i] <= EW'(pt[i]) - EW'(ca[i]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: the fifteen per-axis products of the five dot products
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] m00 [3];
  logic signed [PW-1:0] m01 [3];
  logic signed [PW-1:0] m11 [3];
  logic signed [PW-1:0] m20 [3];
  logic signed [PW-1:0] m21 [3];

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      for (int i = 0; i < 3; i++) begin
        m00[i] <= e0[i] * e0[i];
        m01[i] <= e0[i] * e1[i];
        m11[i] <= e1[i] * e1[i];
        m20[i] <= e2[i] * e0[i];
        m21[i] <= e2[i] * e1[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: dot products d00, d01, d11, d20, d21
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] d00, d01, d11, d20, d21;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      d00 <= DW'(m00[0]) + DW'(m00[1]) + DW'(m00[2]);
      d01 <= DW'(m01[0]) + DW'(m01[1]) + DW'(m01[2]);
      d11 <= DW'(m11[0]) + DW'(m11[1]) + DW'(m11[2]);
      d20 <= DW'(m20[0]) + DW'(m20[1]) + DW'(m20[2]);
      d21 <= DW'(m21[0]) + DW'(m21[1]) + DW'(m21[2]);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: partial products of the six wide products
  //   0: d00*d11  1: d01*d01  (den = 0 - 1)
  //   2: d11*d20  3: d01*d21  (nv  = 2 - 3)
  //   4: d00*d21  5: d01*d20  (nw  = 4 - 5)
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] mul_a [6];
  logic signed [DW-1:0] mul_b [6];

  assign mul_a = '{d00, d01, d11, d01, d00, d01};
  assign mul_b = '{d11, d01, d20, d21, d21, d20};

  logic signed [LOW-1:0] part_lo [6];
  logic signed [HIW-1:0] part_hi [6];

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      for (int k = 0; k < 6; k++) begin
        part_lo[k] <= mul_a[k] * $signed({1'b0, mul_b[k][LW-1:0]});
        part_hi[k] <= mul_a[k] * $signed(mul_b[k][DW-1:LW]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: recombine the partial products
  // ---------------------------------------------------------------------------
  logic signed [PRW-1:0] prod [6];

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      for (int k = 0; k < 6; k++) begin
        prod[k] <= (PRW'(part_hi[k]) <<< LW) + PRW'(part_lo[k]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: denominator and the v and w numerators
  // ---------------------------------------------------------------------------
  logic signed [NW-1:0] den, nv, nw;

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      den <= NW'(prod[0]) - NW'(prod[1]);
      nv  <= NW'(prod[2]) - NW'(prod[3]);
      nw  <= NW'(prod[4]) - NW'(prod[5]);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7: u numerator, |den|, sign tests on v and w
  // ---------------------------------------------------------------------------
  logic signed [NW-1:0] nu;
  logic        [NW-1:0] den_mag;
  logic                 den_neg7;
  logic                 den_zero7;
  logic                 v_ok, w_ok;

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      nu        <= den - nv - nw;
      den_mag   <= den[NW-1] ? NW'(-den) : NW'(den);
      den_neg7  <= den[NW-1];
      den_zero7 <= (den == '0);
      // a ratio is non-negative when its numerator is zero or shares the sign of den
      v_ok      <= (nv == '0) || (nv[NW-1] == den[NW-1]);
      w_ok      <= (nw == '0) || (nw[NW-1] == den[NW-1]);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 8: degenerate compare and final decision into the result register
  // ---------------------------------------------------------------------------
  logic u_ok;
  logic degen_next;

  assign u_ok       = (nu == '0) || (nu[NW-1] == den_neg7);
  assign degen_next = (den_mag[NW-1:LMW] == '0) && (den_mag[LMW-1:0] < degenerate_limit);

  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      degenerate <= degen_next;
      // a zero denominator with a zero limit is not degenerate but still reports outside
      inside_res <= !degen_next && !den_zero7 && v_ok && w_ok && u_ok;
    end
  end

endmodule

### rtl/pitb_checker.sv
// port-level checks for the point-in-triangle unit, bound to the top level
`include "point_in_triangle_barycentric_unit_macros.svh"

module pitb_checker (
  input logic clk,
  input logic rst,
  input logic query_ready,
  input logic result_valid,
  input logic result_ready,
  input logic inside_res,
  input logic degenerate
);

  // a stalled result beat holds
  `PITB_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(inside_res) && $stable(degenerate), "result beat changed while stalled")

  // a degenerate triangle never reports the point inside
  `PITB_ASSERT_NOW(a_degen_outside, result_valid && degenerate, !inside_res, "inside reported for degenerate triangle")

  // with the result register free the pipeline can always take a query
  `PITB_ASSERT_NOW(a_ready_when_free, !result_valid || result_ready, query_ready, "query stalled with free output")

  // no result straight after reset
  `PITB_ASSERT_NOW(a_empty_after_reset, $past(rst), !result_valid, "result beat right after reset")

endmodule

bind point_in_triangle_barycentric_unit pitb_checker u_pitb_checker (
  .clk          (clk),
  .rst          (rst),
  .query_ready  (query_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .inside_res   (inside_res),
  .degenerate   (degenerate)
);
